// ===== design/lsmf_pkg.sv =====
package lsmf_pkg;

	// Character codes that steer line handling
	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic [7:0] END_CHAR     = 8'd0;

	// Pattern register layout: two 64-bit halves, eight bytes each
	localparam int PAT_REG_BYTES = 16;
	localparam int PAT_LEN_W     = 5;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_INDEX_W   = 2;

	// Default window depth
	localparam int PATTERN_BYTES_DEF = 16;

	// Buffer size limit and the saturation points that follow from it
	localparam int MAX_BYTES  = 65536;
	localparam int OFFSET_W   = 16;
	localparam int LINE_NUM_W = 17;
	localparam logic [OFFSET_W-1:0] OFFSET_TOP =
		OFFSET_W'(((MAX_BYTES - 1) < 65535) ? (MAX_BYTES - 1) : 65535);
	localparam logic [LINE_NUM_W-1:0] LINE_TOP =
		LINE_NUM_W'((MAX_BYTES < 131071) ? MAX_BYTES : 131071);

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PAT_FIRST  = 2'd0,
		CFG_PAT_SECOND = 2'd1,
		CFG_PAT_LEN    = 2'd2
	} cfg_reg_t;

	typedef logic [PAT_REG_BYTES-1:0][7:0] pat_bytes_t;

	// Byte classification for the stage that updates line state
	typedef struct packed {
		logic fire;
		logic is_end;
		logic is_newline;
		logic last;
	} step_ctl_t;

	// Report for one closed line
	typedef struct packed {
		logic                  emit;
		logic [LINE_NUM_W-1:0] number;
		logic [OFFSET_W-1:0]   start;
		logic [OFFSET_W-1:0]   length;
	} line_rpt_t;

endpackage

// ===== design/line_substring_match_filter.sv =====
// Line substring filter: scans a byte stream at one byte per clock and, for
// every line that holds the programmed pattern (up to PATTERN_BYTES bytes,
// zero length matches every line), returns its one-based number, start offset
// and length. A line closes at a newline, at a byte flagged last_byte, or at
// a zero byte; a zero byte or last_byte ends the buffer and counters restart.
// Each byte passes through an input register, then through window compare
// and counter update into the result register, so a report is registered
// in the result register when the byte that closes its line leaves the input
// register, and a new byte is taken every cycle while the result register is
// free or being drained. Program the pattern only while the block is idle.
module line_substring_match_filter
	import lsmf_pkg::*;
#(
	parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// byte input
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	// match report output
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [LINE_NUM_W-1:0]  line_number,
	output logic [OFFSET_W-1:0]    line_start,
	output logic [OFFSET_W-1:0]    line_length
);

	logic [CFG_DATA_W-1:0] pat_first_q;
	logic [CFG_DATA_W-1:0] pat_second_q;
	logic [PAT_LEN_W-1:0]  pat_len_q;
	pat_bytes_t            pattern;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	step_ctl_t  ctl;
	logic       line_hit;
	line_rpt_t  rpt;

	logic                  out_valid_q;
	logic [LINE_NUM_W-1:0] number_q;
	logic [OFFSET_W-1:0]   start_q;
	logic [OFFSET_W-1:0]   length_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_first_q  <= '0;
			pat_second_q <= '0;
			pat_len_q    <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_PAT_FIRST:  pat_first_q  <= cfg_data;
				CFG_PAT_SECOND: pat_second_q <= cfg_data;
				CFG_PAT_LEN:    pat_len_q    <= cfg_data[PAT_LEN_W-1:0];
				default:        ;
			endcase
		end
	end

	assign pattern = {pat_second_q, pat_first_q};

	// Stage 1 advances when the result register is free or drains this cycle
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Classify the registered byte
	always_comb begin
		ctl.fire       = advance;
		ctl.is_end     = (byte_s1 == END_CHAR);
		ctl.is_newline = (byte_s1 == NEWLINE_CHAR);
		ctl.last       = last_s1;
	end

	lsmf_window_match #(
		.PATTERN_BYTES(PATTERN_BYTES)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.data_byte     (byte_s1),
		.pattern       (pattern),
		.pattern_length(pat_len_q),
		.line_hit      (line_hit)
	);

	lsmf_line_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.line_hit(line_hit),
		.rpt     (rpt)
	);

	// Result register: load on a report, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= rpt.emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt.emit) begin
			number_q <= rpt.number;
			start_q  <= rpt.start;
			length_q <= rpt.length;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_number = number_q;
	assign line_start  = start_q;
	assign line_length = length_q;

endmodule

// ===== design/lsmf_window_match.sv =====
module lsmf_window_match
	import lsmf_pkg::*;
#(
	parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  step_ctl_t            ctl,
	input  logic [7:0]           data_byte,
	input  pat_bytes_t           pattern,
	input  logic [PAT_LEN_W-1:0] pattern_length,
	output logic                 line_hit
);

	localparam int LEN_W = $clog2(PATTERN_BYTES + 1);

	logic [PATTERN_BYTES-1:0][7:0] recent_q;
	logic [PATTERN_BYTES-1:0][7:0] win_new;
	logic [LEN_W-1:0]              count_q;
	logic [LEN_W-1:0]              count_new;
	logic                          match_q;
	logic [LEN_W-1:0]              used_len;
	logic [PATTERN_BYTES:0]        len_match;
	logic                          match_now;
	logic                          normal_byte;
	logic                          clear_line;

	// Clip the programmed length to the window depth
	always_comb begin
		if (pattern_length > PAT_LEN_W'(PATTERN_BYTES))
			used_len = LEN_W'(PATTERN_BYTES);
		else
			used_len = LEN_W'(pattern_length);
	end

	// Window after shifting in the current byte, newest at index 0
	always_comb begin
		win_new[0] = data_byte;
		for (int i = 1; i < PATTERN_BYTES; i++)
			win_new[i] = recent_q[i-1];
		if (count_q < LEN_W'(PATTERN_BYTES))
			count_new = count_q + LEN_W'(1);
		else
			count_new = count_q;
	end

	// Compare the window against every nonzero pattern length in parallel
	always_comb begin
		len_match[0] = 1'b0;
		for (int l = 1; l <= PATTERN_BYTES; l++) begin
			len_match[l] = (count_new >= LEN_W'(l));
			for (int k = 0; k < l; k++) begin
				if (win_new[l-1-k] != pattern[k])
					len_match[l] = 1'b0;
			end
		end
		match_now = len_match[used_len];
	end

	assign normal_byte = !ctl.is_end && !ctl.is_newline;
	assign clear_line  = ctl.is_end || ctl.is_newline || ctl.last;

	// A line hits on an earlier match, on this byte's match, or on an empty pattern
	assign line_hit = match_q || (normal_byte && match_now) || (used_len == '0);

	// Shift the window or drop it when the line closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			count_q  <= '0;
			match_q  <= 1'b0;
		end else if (ctl.fire) begin
			if (clear_line) begin
				recent_q <= '0;
				count_q  <= '0;
				match_q  <= 1'b0;
			end else begin
				recent_q <= win_new;
				count_q  <= count_new;
				match_q  <= match_q || match_now;
			end
		end
	end

endmodule

// ===== design/lsmf_line_tracker.sv =====
module lsmf_line_tracker
	import lsmf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  step_ctl_t ctl,
	input  logic      line_hit,
	output line_rpt_t rpt
);

	logic [OFFSET_W-1:0]   offset_q;
	logic [OFFSET_W-1:0]   start_q;
	logic [LINE_NUM_W-1:0] line_q;
	logic [OFFSET_W-1:0]   offset_d;
	logic [OFFSET_W-1:0]   start_d;
	logic [LINE_NUM_W-1:0] line_d;
	logic [OFFSET_W-1:0]   next_off;
	logic [OFFSET_W-1:0]   len_here;
	logic [OFFSET_W-1:0]   len_next;
	logic [LINE_NUM_W-1:0] line_inc;
	logic                  restart;

	// Saturating offset and line counters
	always_comb begin
		next_off = (offset_q == OFFSET_TOP) ? offset_q : offset_q + OFFSET_W'(1);
		line_inc = (line_q < LINE_TOP) ? line_q + LINE_NUM_W'(1) : line_q;
		len_here = offset_q - start_q;
		len_next = next_off - start_q;
	end

	// Decide the report and the next counter values for this byte
	always_comb begin
		rpt.emit   = 1'b0;
		rpt.number = line_q;
		rpt.start  = start_q;
		rpt.length = len_here;
		offset_d   = offset_q;
		start_d    = start_q;
		line_d     = line_q;
		restart    = 1'b0;
		if (ctl.is_end) begin
			rpt.emit = line_hit && (len_here != '0);
			restart  = 1'b1;
		end else if (ctl.is_newline) begin
			rpt.emit = line_hit;
			offset_d = next_off;
			start_d  = next_off;
			line_d   = line_inc;
			restart  = ctl.last;
		end else begin
			offset_d = next_off;
			if (ctl.last) begin
				rpt.length = len_next;
				rpt.emit   = line_hit && (len_next != '0);
				restart    = 1'b1;
			end
		end
		rpt.emit = rpt.emit && ctl.fire;
	end

	// Advance counters; restart them at the end of a buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			start_q  <= '0;
			line_q   <= LINE_NUM_W'(1);
		end else if (ctl.fire) begin
			if (restart) begin
				offset_q <= '0;
				start_q  <= '0;
				line_q   <= LINE_NUM_W'(1);
			end else begin
				offset_q <= offset_d;
				start_q  <= start_d;
				line_q   <= line_d;
			end
		end
	end

endmodule
